FILE: src/fprc_pkg.sv
// Package for the frame plane run-length encoder with CRC-32 check.
// Holds request, phase and status codes, item/result structs and the CRC step.
// No dependencies.
package fprc_pkg;

  localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
  localparam logic [31:0] CrcAllOnes  = 32'hFFFF_FFFF;
  localparam logic [7:0]  RunMax      = 8'd255;
  localparam logic [15:0] PlaneSizeRst = 16'd10800;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    REQ_BEGIN  = 2'd0,
    REQ_DATA   = 2'd1,
    REQ_FINISH = 2'd2,
    REQ_ABORT  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_BLACK  = 3'd1,
    PH_RED    = 3'd2,
    PH_DONE   = 3'd3,
    PH_FAILED = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_STARTED = 3'd1,
    ST_TRAILING    = 3'd2,
    ST_INCOMPLETE  = 3'd3,
    ST_CRC         = 3'd4,
    ST_NOTHING     = 3'd5
  } status_e;

  typedef enum logic {
    CFG_PLANE_SIZE   = 1'b0,
    CFG_EXPECTED_CRC = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    KIND_TOKEN  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       chunk_end;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  run_count;
    logic [7:0]  run_value;
    logic [2:0]  status_code;
    logic [16:0] black_bytes;
    logic [16:0] red_bytes;
    logic        last_result;
  } res_t;

  // Results produced by one item: up to two, in order res0 then res1.
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } push_t;

  // Reflected CRC-32 update over one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic res_t make_token(input logic [7:0] cnt, input logic [7:0] val);
    res_t r;
    r             = '0;
    r.result_kind = KIND_TOKEN;
    r.run_count   = cnt;
    r.run_value   = val;
    return r;
  endfunction

  function automatic res_t make_status(input status_e st, input logic [16:0] blk,
                                       input logic [16:0] red);
    res_t r;
    r             = '0;
    r.result_kind = KIND_STATUS;
    r.status_code = st;
    r.black_bytes = blk;
    r.red_bytes   = red;
    return r;
  endfunction

endpackage

FILE: src/fprc_if.sv
// Channel interfaces of the frame plane encoder: request, result and config write.
// Plain valid/ready handshakes; no package dependency.
interface fprc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source (output valid, req_type, data_byte, chunk_end, input ready);
  modport sink   (input valid, req_type, data_byte, chunk_end, output ready);
endinterface

interface fprc_res_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  run_count;
  logic [7:0]  run_value;
  logic [2:0]  status_code;
  logic [16:0] black_bytes;
  logic [16:0] red_bytes;
  logic        last_result;

  modport source (output valid, result_kind, run_count, run_value, status_code,
                  black_bytes, red_bytes, last_result, input ready);
  modport sink   (input valid, result_kind, run_count, run_value, status_code,
                  black_bytes, red_bytes, last_result, output ready);
endinterface

interface fprc_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/frame_plane_rle_crc_encoder.sv
// Top level of the frame plane run-length encoder with CRC-32 check.
// Depends on fprc_pkg, fprc_if, fprc_core and fprc_outq.
//
//   port    | dir | content
//   --------+-----+-----------------------------------------------
//   req_i   | in  | begin / data byte / finish / abort requests
//   res_o   | out | run tokens and status reports
//   cfg_i   | in  | plane_size (index 0), expected_crc (index 1)
//
// One request is taken per cycle unless stalled; it is held in the input register,
// then the frame logic folds it in and pushes 0..2 results into a 4-entry queue.
// A data byte that ends a plane and closes a run yields two results, so
// sustained rate is bounded by one result transfer per cycle at the output.
// Requests stall only while the queue lacks room for two results.
// Reset is asynchronous; config is written at any time with ready held high.
module frame_plane_rle_crc_encoder (
  input  logic  clk_i,
  input  logic  rst_ni,
  fprc_req_if.sink   req_i,
  fprc_res_if.source res_o,
  fprc_cfg_if.sink   cfg_i
);
  import fprc_pkg::*;

  logic [15:0] plane_size_q;
  logic [31:0] expected_crc_q;
  item_t       in_q;
  logic        in_vld_q;
  logic        room, advance, accept;
  push_t       push;
  res_t        head;

  assign advance     = in_vld_q && room;
  assign req_i.ready = !in_vld_q || advance;
  assign accept      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_size_q   <= PlaneSizeRst;
      expected_crc_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_PLANE_SIZE:   plane_size_q   <= cfg_i.data[15:0];
        CFG_EXPECTED_CRC: expected_crc_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // hold the item until the queue can take its results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.req_type  <= req_i.req_type;
      in_q.data_byte <= req_i.data_byte;
      in_q.chunk_end <= req_i.chunk_end;
    end
  end

  fprc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .plane_size_i   (plane_size_q),
    .expected_crc_i (expected_crc_q),
    .step_i         (advance),
    .item_i         (in_q),
    .push_o         (push)
  );

  fprc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .head_o  (head)
  );

  assign res_o.result_kind = head.result_kind;
  assign res_o.run_count   = head.run_count;
  assign res_o.run_value   = head.run_value;
  assign res_o.status_code = head.status_code;
  assign res_o.black_bytes = head.black_bytes;
  assign res_o.red_bytes   = head.red_bytes;
  assign res_o.last_result = head.last_result;

endmodule

FILE: src/fprc_core.sv
// Frame state, CRC-32 and run-length encoder: one item per step, up to two results.
// Depends on fprc_pkg.
module fprc_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     plane_size_i,
  input  logic [31:0]     expected_crc_i,
  input  logic            step_i,
  input  fprc_pkg::item_t item_i,
  output fprc_pkg::push_t push_o
);
  import fprc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  val_q, val_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [31:0] crc_q, crc_d;
  logic [17:0] total_q, total_d;
  logic [17:0] black_q, black_d;
  logic        drop_q, drop_d;

  logic        extend, close_run, plane_end;
  logic [7:0]  cnt_new, val_new;
  logic [15:0] pos_inc;
  logic [17:0] tot1, tot2, red_total;
  push_t       push;

  always_comb begin
    extend    = (cnt_q != 8'd0) && (item_i.data_byte == val_q) && (cnt_q != RunMax);
    close_run = !extend && (cnt_q != 8'd0);
    cnt_new   = extend ? cnt_q + 8'd1 : 8'd1;
    val_new   = extend ? val_q : item_i.data_byte;
    pos_inc   = pos_q + 16'd1;
    // a zero or lowered plane size ends the plane right after this byte
    plane_end = (pos_inc == 16'd0) || (pos_inc >= plane_size_i);
    tot1      = close_run ? total_q + 18'd2 : total_q;
    tot2      = plane_end ? tot1 + 18'd2 : tot1;
    red_total = total_q - black_q;
  end

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    total_d = total_q;
    black_d = black_q;
    drop_d  = drop_q;
    push    = '0;
    case (req_e'(item_i.req_type))
      REQ_BEGIN: begin
        phase_d = PH_BLACK;
        pos_d   = '0;
        val_d   = '0;
        cnt_d   = '0;
        crc_d   = CrcAllOnes;
        total_d = '0;
        black_d = '0;
        drop_d  = 1'b0;
      end
      REQ_ABORT: begin
        phase_d = PH_IDLE;
        drop_d  = 1'b0;
      end
      REQ_FINISH: begin
        phase_d    = PH_IDLE;
        drop_d     = 1'b0;
        push.count = 2'd1;
        if (phase_q == PH_IDLE) begin
          push.res0 = make_status(ST_NOTHING, '0, '0);
        end else if (phase_q != PH_DONE) begin
          push.res0 = make_status(ST_INCOMPLETE, '0, '0);
        end else if ((crc_q ^ CrcAllOnes) != expected_crc_i) begin
          push.res0 = make_status(ST_CRC, '0, '0);
        end else begin
          push.res0 = make_status(ST_OK, black_q[16:0], red_total[16:0]);
        end
      end
      default: begin
        if (drop_q) begin
          if (item_i.chunk_end) drop_d = 1'b0;
        end else if (phase_q == PH_BLACK || phase_q == PH_RED) begin
          crc_d   = crc_byte(crc_q, item_i.data_byte);
          val_d   = val_new;
          cnt_d   = plane_end ? 8'd0 : cnt_new;
          pos_d   = plane_end ? 16'd0 : pos_inc;
          total_d = tot2;
          push.count = {1'b0, close_run} + {1'b0, plane_end};
          if (close_run) begin
            push.res0 = make_token(cnt_q, val_q);
            push.res1 = make_token(cnt_new, val_new);
          end else begin
            push.res0 = make_token(cnt_new, val_new);
          end
          if (plane_end) begin
            if (phase_q == PH_BLACK) begin
              black_d = tot2;
              phase_d = PH_RED;
            end else begin
              phase_d = PH_DONE;
            end
          end
        end else if (phase_q == PH_DONE) begin
          phase_d    = PH_FAILED;
          drop_d     = !item_i.chunk_end;
          push.count = 2'd1;
          push.res0  = make_status(ST_TRAILING, '0, '0);
        end else begin
          drop_d     = !item_i.chunk_end;
          push.count = 2'd1;
          push.res0  = make_status(ST_NOT_STARTED, '0, '0);
        end
      end
    endcase
    // flag the final result of this item
    if (push.count == 2'd1) push.res0.last_result = 1'b1;
    if (push.count == 2'd2) push.res1.last_result = 1'b1;
  end

  assign push_o = step_i ? push : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      val_q   <= '0;
      cnt_q   <= '0;
      crc_q   <= CrcAllOnes;
      total_q <= '0;
      black_q <= '0;
      drop_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      val_q   <= val_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      total_q <= total_d;
      black_q <= black_d;
      drop_q  <= drop_d;
    end
  end

endmodule

FILE: src/fprc_outq.sv
// Result queue of the frame plane encoder: takes up to two results a cycle,
// hands out one per transfer. Depends on fprc_pkg.
module fprc_outq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fprc_pkg::push_t       push_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output fprc_pkg::res_t        head_o
);
  import fprc_pkg::*;

  localparam logic [QueuePtrW:0] RoomLimit = (QueuePtrW + 1)'(QueueDepth - 2);

  res_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q, wr_nx;
  logic [QueuePtrW:0]   cnt_q, cnt_d;
  logic                 pop;

  assign wr_nx   = wr_q + 1'b1;
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign room_o  = cnt_q <= RoomLimit;
  assign pop     = valid_o && ready_i;
  assign cnt_d   = cnt_q + {{(QueuePtrW - 1){1'b0}}, push_i.count} - {{QueuePtrW{1'b0}}, pop};

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.res0;
    if (push_i.count == 2'd2) mem_q[wr_nx] <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.count[QueuePtrW-1:0];
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule
